### hw/rtl/kuf_pkg.sv
// ----------------------------------------------------------------------------
// kuf_pkg
// Shared types and codes for the keyed unique FIFO: beat layouts,
// operation codes, status codes and the default depth.
// ----------------------------------------------------------------------------
package kuf_pkg;

   localparam int DEFAULT_DEPTH = 16;

   localparam int FUNC_W   = 2;
   localparam int KEY_W    = 31;
   localparam int HANDLE_W = 16;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 5;

   // operation codes
   localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_DUPLICATE = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd4;

   typedef struct packed {
      logic [FUNC_W-1:0]   func;
      logic [KEY_W-1:0]    key;
      logic [HANDLE_W-1:0] handle;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [HANDLE_W-1:0] found_handle;
      logic [COUNT_W-1:0]  count;
      logic                is_empty;
      logic [HANDLE_W-1:0] head_handle;
   } rsp_type;

endpackage

### hw/rtl/kuf_ram.sv
// ----------------------------------------------------------------------------
// kuf_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module kuf_ram #(
   parameter int WIDTH  = 16,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/keyed_unique_fifo_unit.sv
// ----------------------------------------------------------------------------
// keyed_unique_fifo_unit
// Bounded FIFO of key/handle records with duplicate-key refusal and
// search by key.
// ----------------------------------------------------------------------------
// The block handles one request beat at a time. Insert and search walk the
// live entries from the head, reading one stored key per cycle from the key
// RAM, so they cover at most count stored keys (count = entries held, at most
// DEPTH; none on an empty queue, fewer on an early match); the single read
// port of the key RAM sets that pace. Remove and the unused function code 3
// skip the walk. Every operation ends with a read of the head handle so the
// response always carries the current head. A finished response sits in an
// output register; a new request is taken while it waits, and the block
// holds its final step until the register is free. The stores are not
// cleared after reset: only live entries are ever read, so the block is
// ready right after reset.
// ----------------------------------------------------------------------------
module keyed_unique_fifo_unit #(
   parameter int DEPTH = kuf_pkg::DEFAULT_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  kuf_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output kuf_pkg::rsp_type rsp_data
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   // sequencer states
   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_SCAN      = 3'd1;
   localparam logic [2:0] S_COMMIT    = 3'd2;
   localparam logic [2:0] S_REMOVE    = 3'd3;
   localparam logic [2:0] S_RM_WAIT   = 3'd4;
   localparam logic [2:0] S_HEAD      = 3'd5;
   localparam logic [2:0] S_HEAD_WAIT = 3'd6;

   // circular pointer advance
   function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] slot);
      if (slot == IDX_W'(DEPTH - 1)) begin
         return '0;
      end
      return slot + IDX_W'(1);
   endfunction

   logic [2:0]                      state_ff, state_in;
   kuf_pkg::req_type                op_ff, op_in;
   logic [IDX_W-1:0]                head_ff, head_in;
   logic [IDX_W-1:0]                tail_ff, tail_in;
   logic [CNT_W-1:0]                count_ff, count_in;
   logic [IDX_W-1:0]                scan_ptr_ff, scan_ptr_in;
   logic [CNT_W-1:0]                issued_ff, issued_in;
   logic                            pend_ff, pend_in;
   logic                            match_ff, match_in;
   logic [kuf_pkg::STATUS_W-1:0]    status_ff, status_in;
   logic [kuf_pkg::HANDLE_W-1:0]    found_ff, found_in;
   kuf_pkg::rsp_type                rsp_ff, rsp_in;
   logic                            rsp_valid_ff, rsp_valid_in;

   logic                            wr_en;
   logic [IDX_W-1:0]                rd_addr;
   logic [kuf_pkg::KEY_W-1:0]       key_rd;
   logic [kuf_pkg::HANDLE_W-1:0]    hnd_rd;
   logic                            issue;
   logic                            hit;
   logic                            rsp_load;

   // key and handle stores share the same addresses
   kuf_ram #(
      .WIDTH  (kuf_pkg::KEY_W),
      .DEPTH  (DEPTH),
      .ADDR_W (IDX_W)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail_ff),
      .wr_data (op_ff.key),
      .rd_addr (rd_addr),
      .rd_data (key_rd)
   );

   kuf_ram #(
      .WIDTH  (kuf_pkg::HANDLE_W),
      .DEPTH  (DEPTH),
      .ADDR_W (IDX_W)
   ) u_handle_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail_ff),
      .wr_data (op_ff.handle),
      .rd_addr (rd_addr),
      .rd_data (hnd_rd)
   );

   // scan walks its own pointer; every other step reads at the head
   assign rd_addr   = (state_ff == S_SCAN) ? scan_ptr_ff : head_ff;
   assign req_stall = (state_ff != S_IDLE);
   assign issue     = (issued_ff != count_ff);
   assign hit       = pend_ff && (key_rd == op_ff.key);
   assign rsp_load  = (state_ff == S_HEAD_WAIT) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      count_in    = count_ff;
      scan_ptr_in = scan_ptr_ff;
      issued_in   = issued_ff;
      pend_in     = pend_ff;
      match_in    = match_ff;
      status_in   = status_ff;
      found_in    = found_ff;
      wr_en       = 1'b0;
      rsp_in      = rsp_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in       = req_data;
               status_in   = kuf_pkg::STATUS_OK;
               found_in    = '0;
               match_in    = 1'b0;
               scan_ptr_in = head_ff;
               issued_in   = '0;
               pend_in     = 1'b0;
               case (req_data.func)
                  kuf_pkg::FUNC_INSERT: state_in = S_SCAN;
                  kuf_pkg::FUNC_SEARCH: state_in = S_SCAN;
                  kuf_pkg::FUNC_REMOVE: state_in = S_REMOVE;
                  default:              state_in = S_HEAD;
               endcase
            end
         end

         S_SCAN: begin
            // issue one key read per cycle, compare the one returned
            if (hit) begin
               match_in = 1'b1;
               found_in = hnd_rd;
               pend_in  = 1'b0;
               state_in = S_COMMIT;
            end else if (!issue && !pend_ff) begin
               state_in = S_COMMIT;
            end else begin
               pend_in = issue;
               if (issue) begin
                  scan_ptr_in = next_slot(scan_ptr_ff);
                  issued_in   = issued_ff + CNT_W'(1);
               end
            end
         end

         S_COMMIT: begin
            if (op_ff.func == kuf_pkg::FUNC_INSERT) begin
               found_in = '0;
               if (match_ff) begin
                  status_in = kuf_pkg::STATUS_DUPLICATE;
               end else if (count_ff == CNT_W'(DEPTH)) begin
                  status_in = kuf_pkg::STATUS_FULL;
               end else begin
                  wr_en    = 1'b1;
                  tail_in  = next_slot(tail_ff);
                  count_in = count_ff + CNT_W'(1);
               end
            end else if (!match_ff) begin
               status_in = kuf_pkg::STATUS_NOT_FOUND;
            end
            state_in = S_HEAD;
         end

         S_REMOVE: begin
            // head handle is read at the old head this cycle
            if (count_ff == '0) begin
               status_in = kuf_pkg::STATUS_EMPTY;
               state_in  = S_HEAD;
            end else begin
               head_in  = next_slot(head_ff);
               count_in = count_ff - CNT_W'(1);
               state_in = S_RM_WAIT;
            end
         end

         S_RM_WAIT: begin
            found_in = hnd_rd;
            state_in = S_HEAD;
         end

         S_HEAD: begin
            state_in = S_HEAD_WAIT;
         end

         S_HEAD_WAIT: begin
            // hold until the output register is free
            if (rsp_load) begin
               rsp_in.status       = status_ff;
               rsp_in.found_handle = found_ff;
               rsp_in.count        = kuf_pkg::COUNT_W'(count_ff);
               rsp_in.is_empty     = (count_ff == '0);
               rsp_in.head_handle  = (count_ff == '0) ? '0 : hnd_rd;
               state_in            = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         issued_ff    <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         issued_ff    <= issued_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      scan_ptr_ff <= scan_ptr_in;
      match_ff    <= match_in;
      status_ff   <= status_in;
      found_ff    <= found_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // occupancy never passes the capacity
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above capacity");

   // scan never reads past the live entries
   assert property (@(posedge clock) disable iff (reset)
      issued_ff <= count_ff)
      else $error("scan issued beyond live entries");

   // an append always grows the queue by one
   assert property (@(posedge clock) disable iff (reset)
      wr_en |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("append did not advance the count");

   // full is reported only at capacity
   assert property (@(posedge clock) disable iff (reset)
      rsp_load && (status_ff == kuf_pkg::STATUS_FULL) |-> count_ff == CNT_W'(DEPTH))
      else $error("full reported below capacity");

endmodule

### verif/keyed_unique_fifo_unit_tb.sv
// ----------------------------------------------------------------------------
// keyed_unique_fifo_unit_tb
// Self-checking bench for the keyed unique FIFO. A directed opening walks the
// empty, duplicate and full corners. Random traffic follows, built from a
// small key pool so that duplicates, search hits and a full queue keep
// coming up. Every accepted request beat runs through a behavioral copy of
// the queue, and each response beat is checked field by field against the
// oldest prediction.
// ----------------------------------------------------------------------------
module keyed_unique_fifo_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = kuf_pkg::DEFAULT_DEPTH;
   // spare function code: the block must answer it without touching the queue
   localparam logic [kuf_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   localparam int RANDOM_ITEMS  = 600;
   localparam int KEY_POOL_SIZE = 24;
   localparam int CALM_TAIL     = 80;     // last beats run with no idling
   localparam int DRAIN_CYCLES  = 40;     // longer than one full-depth scan
   localparam int CYCLE_LIMIT   = 200000;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   kuf_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   kuf_pkg::rsp_type rsp_data;

   keyed_unique_fifo_unit #(
      .DEPTH(DEPTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   // 20 ns period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Shadow copy of the queue: circular key/handle storage, head slot, fill.
   logic [kuf_pkg::KEY_W-1:0]    shadow_keys    [DEPTH];
   logic [kuf_pkg::HANDLE_W-1:0] shadow_handles [DEPTH];
   int unsigned                  shadow_head = 0;
   int unsigned                  shadow_fill = 0;

   kuf_pkg::req_type          pending_reqs [$];   // beats not yet offered to the block
   kuf_pkg::rsp_type          expected_rsps[$];   // predicted responses, oldest first
   logic [kuf_pkg::KEY_W-1:0] key_pool [KEY_POOL_SIZE];

   int          error_count    = 0;
   int unsigned cycle_count    = 0;
   logic        req_beat_taken = 1'b0;
   int          send_gap       = 0;
   int          hold_left      = 0;
   int          send_idle_pct  = 0;
   int          recv_idle_pct  = 0;

   // Apply one operation to the shadow queue and return the response it owes.
   function automatic kuf_pkg::rsp_type fifo_op_response(kuf_pkg::req_type op);
      kuf_pkg::rsp_type r;
      logic             matched;
      int unsigned      hit_slot;
      int unsigned      slot;
      r        = '0;
      r.status = kuf_pkg::STATUS_OK;
      matched  = 1'b0;
      hit_slot = 0;
      // oldest live entry with a matching key wins
      for (int i = 0; i < DEPTH; i++) begin
         slot = (shadow_head + i) % DEPTH;
         if (!matched && i < shadow_fill && shadow_keys[slot] == op.key) begin
            matched  = 1'b1;
            hit_slot = slot;
         end
      end
      case (op.func)
         kuf_pkg::FUNC_INSERT: begin
            // duplicate check comes ahead of the full check
            if (matched) begin
               r.status = kuf_pkg::STATUS_DUPLICATE;
            end else if (shadow_fill >= DEPTH) begin
               r.status = kuf_pkg::STATUS_FULL;
            end else begin
               slot                 = (shadow_head + shadow_fill) % DEPTH;
               shadow_keys[slot]    = op.key;
               shadow_handles[slot] = op.handle;
               shadow_fill++;
            end
         end
         kuf_pkg::FUNC_REMOVE: begin
            if (shadow_fill == 0) begin
               r.status = kuf_pkg::STATUS_EMPTY;
            end else begin
               r.found_handle = shadow_handles[shadow_head];
               shadow_head    = (shadow_head + 1) % DEPTH;
               shadow_fill--;
            end
         end
         kuf_pkg::FUNC_SEARCH: begin
            if (matched) begin
               r.found_handle = shadow_handles[hit_slot];
            end else begin
               r.status = kuf_pkg::STATUS_NOT_FOUND;
            end
         end
         default: ;   // spare code: status ok, queue untouched
      endcase
      r.count       = shadow_fill[kuf_pkg::COUNT_W-1:0];
      r.is_empty    = (shadow_fill == 0);
      r.head_handle = (shadow_fill == 0) ? '0 : shadow_handles[shadow_head];
      return r;
   endfunction

   task automatic queue_req(logic [kuf_pkg::FUNC_W-1:0] f, logic [kuf_pkg::KEY_W-1:0] k,
                            logic [kuf_pkg::HANDLE_W-1:0] h);
      kuf_pkg::req_type item;
      item.func   = f;
      item.key    = k;
      item.handle = h;
      pending_reqs.push_back(item);
   endtask

   // Mostly pool keys so duplicates and hits recur; some fully random ones.
   function automatic logic [kuf_pkg::KEY_W-1:0] pick_key();
      if ($urandom_range(99) < 75)
         return key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
      return kuf_pkg::KEY_W'($urandom());
   endfunction

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0h, got %0h",
                  $time, name, want, got);
      end
   endtask

   // Request driver: advance on a taken beat, hold a stalled one unchanged,
   // and drop in idle bursts while far from the end.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_beat_taken) begin
         if (send_gap > 0) begin
            send_gap  <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() == 0) begin
            req_valid <= 1'b0;
         end else if (pending_reqs.size() > CALM_TAIL &&
                      $urandom_range(99) < send_idle_pct) begin
            send_gap  <= $urandom_range(12, 0);
            req_valid <= 1'b0;
         end else begin
            req_data  <= pending_reqs.pop_front();
            req_valid <= 1'b1;
         end
      end
      req_beat_taken <= 1'b0;
   end

   // Response backpressure: stall bursts, none near the end.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (pending_reqs.size() > CALM_TAIL &&
                   $urandom_range(99) < recv_idle_pct) begin
         rsp_stall <= 1'b1;
         hold_left <= $urandom_range(12, 0);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Sample both channels at the rising edge: predict on an accepted request
   // beat, check on an accepted response beat.
   always @(posedge clock) begin
      kuf_pkg::rsp_type want;
      cycle_count <= cycle_count + 1;
      // reshuffle idle density now and then, including stretches of none
      if (cycle_count % 64 == 0) begin
         case ($urandom_range(3))
            0:       send_idle_pct <= 0;
            1:       send_idle_pct <= 8;
            2:       send_idle_pct <= 20;
            default: send_idle_pct <= 40;
         endcase
         case ($urandom_range(3))
            0:       recv_idle_pct <= 0;
            1:       recv_idle_pct <= 8;
            2:       recv_idle_pct <= 20;
            default: recv_idle_pct <= 40;
         endcase
      end
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_rsps.push_back(fifo_op_response(req_data));
            req_beat_taken <= 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               error_count++;
               $display("%0t: unexpected response beat, expected none, got %0h",
                        $time, rsp_data);
            end else begin
               want = expected_rsps.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_data.status));
               check_field("found_handle", 32'(want.found_handle),
                           32'(rsp_data.found_handle));
               check_field("count", 32'(want.count), 32'(rsp_data.count));
               check_field("is_empty", 32'(want.is_empty), 32'(rsp_data.is_empty));
               check_field("head_handle", 32'(want.head_handle),
                           32'(rsp_data.head_handle));
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      if (cycle_count == CYCLE_LIMIT) begin
         $display("keyed_unique_fifo_unit verification failed");
         $finish;
      end
   end

   initial begin
      int op_bias;
      int roll;
      int insert_pct;
      int remove_pct;
      for (int i = 0; i < KEY_POOL_SIZE; i++)
         key_pool[i] = kuf_pkg::KEY_W'($urandom());

      // Directed opening: empty corners, key/handle extremes, duplicate,
      // then fill to the brim and hit duplicate-while-full and plain full.
      queue_req(kuf_pkg::FUNC_REMOVE, '0, '0);
      queue_req(kuf_pkg::FUNC_SEARCH, '1, '1);
      queue_req(FUNC_UNUSED, '0, '0);
      queue_req(kuf_pkg::FUNC_INSERT, '0, '0);
      queue_req(kuf_pkg::FUNC_INSERT, '1, '1);
      queue_req(kuf_pkg::FUNC_INSERT, '0, 16'h5a5a);
      queue_req(kuf_pkg::FUNC_SEARCH, '1, '0);
      queue_req(kuf_pkg::FUNC_SEARCH, 31'h0000_1234, '0);
      queue_req(FUNC_UNUSED, '1, '1);
      for (int i = 1; i <= DEPTH - 2; i++)
         queue_req(kuf_pkg::FUNC_INSERT, kuf_pkg::KEY_W'(i),
                   kuf_pkg::HANDLE_W'(16'h0100 + i));
      queue_req(kuf_pkg::FUNC_INSERT, '0, 16'h0bad);
      queue_req(kuf_pkg::FUNC_INSERT, 31'd100, 16'h0bad);

      // Random traffic in phases that lean toward filling, draining or a mix.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 40 == 0)
            op_bias = $urandom_range(2);
         case (op_bias)
            0:       begin insert_pct = 60; remove_pct = 15; end
            1:       begin insert_pct = 15; remove_pct = 60; end
            default: begin insert_pct = 35; remove_pct = 30; end
         endcase
         roll = $urandom_range(99);
         if (roll < 3)
            queue_req(FUNC_UNUSED, kuf_pkg::KEY_W'($urandom()),
                      kuf_pkg::HANDLE_W'($urandom_range(16'hffff)));
         else if (roll < 3 + insert_pct)
            queue_req(kuf_pkg::FUNC_INSERT, pick_key(),
                      kuf_pkg::HANDLE_W'($urandom_range(16'hffff)));
         else if (roll < 3 + insert_pct + remove_pct)
            queue_req(kuf_pkg::FUNC_REMOVE, pick_key(),
                      kuf_pkg::HANDLE_W'($urandom_range(16'hffff)));
         else
            queue_req(kuf_pkg::FUNC_SEARCH, pick_key(),
                      kuf_pkg::HANDLE_W'($urandom_range(16'hffff)));
      end

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Let every beat go out, every response come back, then watch for strays.
      while (pending_reqs.size() != 0 || req_valid)
         @(negedge clock);
      while (expected_rsps.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (error_count == 0)
         $display("keyed_unique_fifo_unit verification clean");
      else
         $display("keyed_unique_fifo_unit verification failed");
      $finish;
   end

endmodule
